// ===== rtl/date_add_days_assert.svh =====
// assertion macros for the date offset block
// no dependencies; uses clk and rst_n of the including module
`ifndef DATE_ADD_DAYS_ASSERT_SVH
`define DATE_ADD_DAYS_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DAD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("date_add_days: assertion failed");

// next-cycle implication, checked out of reset
`define DAD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("date_add_days: assertion failed");

`endif

// ===== rtl/dad_pkg.sv =====
// shared types and constants for the date offset block
// no dependencies
`timescale 1ns / 1ps

package dad_pkg;

    localparam int CYCLE_DAYS  = 146097;
    localparam int CYCLE_YEARS = 400;
    localparam int YEAR_MAX    = 9999;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_CYCLE,
        ST_WALK_FWD,
        ST_WALK_BWD,
        ST_DONE
    } st_t;

    // month step information from the calendar unit
    typedef struct packed {
        logic [4:0] len_cur;
        logic [3:0] next_month;
        logic [8:0] next_ymod;
        logic       next_wrap;
        logic [3:0] prev_month;
        logic [8:0] prev_ymod;
        logic       prev_wrap;
        logic [4:0] len_prev;
    } month_info_t;

endpackage

// ===== rtl/dad_month_unit.sv =====
// calendar unit: month lengths and neighbouring months under the gregorian rule
// depends on dad_pkg
`timescale 1ns / 1ps

module dad_month_unit (
    input  logic [3:0]          month,
    input  logic [8:0]          ymod,
    output dad_pkg::month_info_t info
);
    import dad_pkg::*;

    function automatic logic is_leap(input logic [8:0] ym);
        logic result;
        result = ((ym[1:0] == 2'd0) && (ym != 9'd100) && (ym != 9'd200) && (ym != 9'd300))
                 || (ym == 9'd0);
        return result;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m) inside
            4'd2:                     len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
            default:                  len = 5'd31;
        endcase
        return len;
    endfunction

    always_comb
    begin
        info.len_cur    = month_len(month, is_leap(ymod));
        info.next_wrap  = (month == 4'd12);
        info.next_month = info.next_wrap ? 4'd1 : month + 4'd1;
        info.next_ymod  = info.next_wrap ? ((ymod == 9'd399) ? 9'd0 : ymod + 9'd1) : ymod;
        info.prev_wrap  = (month == 4'd1);
        info.prev_month = info.prev_wrap ? 4'd12 : month - 4'd1;
        info.prev_ymod  = info.prev_wrap ? ((ymod == 9'd0) ? 9'd399 : ymod - 9'd1) : ymod;
        info.len_prev   = month_len(info.prev_month, is_leap(info.prev_ymod));
    end

endmodule

// ===== rtl/date_add_days.sv =====
// top level of the gregorian date offset block: sequencer, day adder, result register
// depends on dad_pkg, dad_month_unit and date_add_days_assert.svh
`timescale 1ns / 1ps

//  channel | direction | payload                               | handshake
//  --------+-----------+---------------------------------------+---------------------
//  in      | to block  | day, month, year, offset              | in_valid / in_stall
//  out     | from block| new_day, new_month, new_year,         | out_valid / out_stall
//          |           | range_error                           |
//
//  an item passes through the year-mod-400 reduction, the 400-year shortcuts, one per
//  cycle, the month walk, one month per cycle, and the hand-over of the result; at the
//  largest 16-bit offset the time taken is set by the one-month-per-cycle walk
//  reset clears the sequencer and the output valid; no clearing pass is needed
//  in_stall is high from acceptance until the result has moved to the output register
//  a result held by out_stall does not block the next item from being accepted

module date_add_days #(
    parameter int OFFSET_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [4:0]                    day,
    input  logic [3:0]                    month,
    input  logic [13:0]                   year,
    input  logic signed [OFFSET_BITS-1:0] offset,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [4:0]                    new_day,
    output logic [3:0]                    new_month,
    output logic [13:0]                   new_year,
    output logic                          range_error
);
    import dad_pkg::*;

    // day count width: must hold day + offset and the 400-year cycle constant
    localparam int TW = ((OFFSET_BITS > 19) ? OFFSET_BITS : 19) + 2;
    // year width: start year plus whole cycles stepped either way
    localparam int YW = ((OFFSET_BITS > 15) ? OFFSET_BITS : 16) + 1;

    localparam logic signed [TW-1:0] T_CYCLE   = TW'(CYCLE_DAYS);
    localparam logic signed [TW-1:0] T_HI_LIM  = TW'(CYCLE_DAYS + 31);
    localparam logic signed [TW-1:0] T_LO_LIM  = TW'(1 - CYCLE_DAYS);
    localparam logic signed [TW-1:0] T_ONE     = TW'(1);
    localparam logic signed [YW-1:0] Y_CYCLE   = YW'(CYCLE_YEARS);
    localparam logic signed [YW-1:0] Y_MAX     = YW'(YEAR_MAX);
    localparam logic [13:0]          YREM_STEP = 14'(CYCLE_YEARS);

    st_t state_reg, state_next;

    logic signed [TW-1:0] t_reg, t_next;       // running day of month
    logic signed [YW-1:0] y_reg, y_next;       // running year
    logic [3:0]           m_reg, m_next;       // running month
    logic [13:0]          yrem_reg, yrem_next; // year mod 400, reduced at start

    logic       out_valid_reg, out_valid_next;
    logic [4:0] new_day_reg, new_day_next;
    logic [3:0] new_month_reg, new_month_next;
    logic [13:0] new_year_reg, new_year_next;
    logic       range_error_reg, range_error_next;

    month_info_t info;

    logic                 in_accept;
    logic                 out_free;
    logic signed [TW-1:0] addend;
    logic signed [TW-1:0] t_sum;
    logic signed [TW-1:0] len_cur_t;
    logic signed [TW-1:0] len_prev_t;
    logic signed [TW-1:0] t_load;
    logic [3:0]           m_load;
    logic                 cyc_down;
    logic                 cyc_up;
    logic                 fwd_step;
    logic                 bwd_step;

    // calendar lookups for the current month and its neighbours
    dad_month_unit u_month (
        .month (m_reg),
        .ymod  (yrem_reg[8:0]),
        .info  (info)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    // output register can take a new result when empty or being drained
    assign out_free  = !out_valid_reg || !out_stall;

    assign len_cur_t  = $signed({{(TW-5){1'b0}}, info.len_cur});
    assign len_prev_t = $signed({{(TW-5){1'b0}}, info.len_prev});
    assign t_load     = $signed({{(TW-5){1'b0}}, day})
                      + $signed({{(TW-OFFSET_BITS){offset[OFFSET_BITS-1]}}, offset});

    // month clamp on entry
    always_comb
    begin
        if (month == 4'd0)
            m_load = 4'd1;
        else if (month > 4'd12)
            m_load = 4'd12;
        else
            m_load = month;
    end

    // loop conditions of the sequencer
    assign cyc_down = (t_reg > T_HI_LIM);
    assign cyc_up   = (t_reg < T_LO_LIM);
    assign fwd_step = (t_reg > len_cur_t);
    assign bwd_step = (t_reg < T_ONE);

    // shared day adder: operand chosen by the step in hand
    always_comb
    begin
        case (state_reg)
            ST_CYCLE:    addend = cyc_down ? -T_CYCLE : T_CYCLE;
            ST_WALK_FWD: addend = -len_cur_t;
            ST_WALK_BWD: addend = len_prev_t;
            default:     addend = '0;
        endcase
    end

    assign t_sum = t_reg + addend;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                    state_next = ST_MOD;
            end
            ST_MOD:
            begin
                if (yrem_reg < YREM_STEP)
                    state_next = ST_CYCLE;
            end
            ST_CYCLE:
            begin
                if (!cyc_down && !cyc_up)
                    state_next = bwd_step ? ST_WALK_BWD : ST_WALK_FWD;
            end
            ST_WALK_FWD:
            begin
                if (!fwd_step)
                    state_next = ST_DONE;
            end
            ST_WALK_BWD:
            begin
                if (!bwd_step)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and result register updates
    always_comb
    begin
        t_next           = t_reg;
        y_next           = y_reg;
        m_next           = m_reg;
        yrem_next        = yrem_reg;
        out_valid_next   = out_valid_reg && out_stall;
        new_day_next     = new_day_reg;
        new_month_next   = new_month_reg;
        new_year_next    = new_year_reg;
        range_error_next = range_error_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    t_next    = t_load;
                    y_next    = $signed({{(YW-14){1'b0}}, year});
                    m_next    = m_load;
                    yrem_next = year;
                end
            end
            ST_MOD:
            begin
                if (yrem_reg >= YREM_STEP)
                    yrem_next = yrem_reg - YREM_STEP;
            end
            ST_CYCLE:
            begin
                // whole 400-year cycles leave the year mod 400 unchanged
                if (cyc_down || cyc_up)
                begin
                    t_next = t_sum;
                    y_next = cyc_down ? y_reg + Y_CYCLE : y_reg - Y_CYCLE;
                end
            end
            ST_WALK_FWD:
            begin
                if (fwd_step)
                begin
                    t_next    = t_sum;
                    m_next    = info.next_month;
                    yrem_next = {5'd0, info.next_ymod};
                    if (info.next_wrap)
                        y_next = y_reg + YW'(1);
                end
            end
            ST_WALK_BWD:
            begin
                if (bwd_step)
                begin
                    t_next    = t_sum;
                    m_next    = info.prev_month;
                    yrem_next = {5'd0, info.prev_ymod};
                    if (info.prev_wrap)
                        y_next = y_reg - YW'(1);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (y_reg < 0)
                    begin
                        // before year zero: clamp to the first day
                        new_day_next     = 5'd1;
                        new_month_next   = 4'd1;
                        new_year_next    = 14'd0;
                        range_error_next = 1'b1;
                    end
                    else if (y_reg > Y_MAX)
                    begin
                        // past the last year: clamp to the last day
                        new_day_next     = 5'd31;
                        new_month_next   = 4'd12;
                        new_year_next    = 14'(YEAR_MAX);
                        range_error_next = 1'b1;
                    end
                    else
                    begin
                        new_day_next     = t_reg[4:0];
                        new_month_next   = m_reg;
                        new_year_next    = y_reg[13:0];
                        range_error_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge clk)
    begin
        t_reg           <= t_next;
        y_reg           <= y_next;
        m_reg           <= m_next;
        yrem_reg        <= yrem_next;
        new_day_reg     <= new_day_next;
        new_month_reg   <= new_month_next;
        new_year_reg    <= new_year_next;
        range_error_reg <= range_error_next;
    end

    assign out_valid   = out_valid_reg;
    assign new_day     = new_day_reg;
    assign new_month   = new_month_reg;
    assign new_year    = new_year_reg;
    assign range_error = range_error_reg;

`include "date_add_days_assert.svh"

    // a clamped result sits on one of the two end years
    `DAD_ASSERT_NOW(a_clamp_year, out_valid_reg && range_error_reg,
        (new_year_reg == 14'd0) || (new_year_reg == 14'(YEAR_MAX)))
    // an in-range result carries a real calendar date
    `DAD_ASSERT_NOW(a_date_ok, out_valid_reg && !range_error_reg,
        (new_day_reg != 5'd0) && (new_month_reg != 4'd0) && (new_month_reg <= 4'd12))
    // the forward walk never drops the day below the first of the month and keeps the year mod 400 reduced
    `DAD_ASSERT_NOW(a_fwd_day, state_reg == ST_WALK_FWD, (t_reg >= T_ONE) && (yrem_reg < YREM_STEP))
    // an accepted item keeps the input side stalled next cycle
    `DAD_ASSERT_NEXT(a_busy, in_accept, in_stall)

endmodule

// ===== dv/date_add_days_checker.sv =====
// result checker for the date offset block: predicts each accepted item, compares results
// depends on dad_pkg for the calendar constants
`timescale 1ns / 1ps

module date_add_days_checker #(
    parameter int OFFSET_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [4:0]                    day,
    input  logic [3:0]                    month,
    input  logic [13:0]                   year,
    input  logic signed [OFFSET_BITS-1:0] offset,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [4:0]                    new_day,
    input  logic [3:0]                    new_month,
    input  logic [13:0]                   new_year,
    input  logic                          range_error,
    output int                            mismatches,
    output int                            pending
);

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic        range_error;
    } shifted_date_t;

    shifted_date_t expected_dates[$];

    initial
    begin
        mismatches = 0;
        pending    = 0;
    end

    function automatic bit leap_year(input longint yr);
        return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    function automatic longint days_in_month(input int mo, input longint yr);
        if (mo == 2)
            return leap_year(yr) ? 29 : 28;
        if (mo == 4 || mo == 6 || mo == 9 || mo == 11)
            return 30;
        return 31;
    endfunction

    // date reached from d/m/y after off days, clamped with a flag outside 0..YEAR_MAX
    function automatic shifted_date_t shift_date(input logic [4:0] d, input logic [3:0] m,
                                                 input logic [13:0] y, input longint off);
        shifted_date_t res;
        longint        dd;
        longint        yr;
        int            mo;
        mo = (m < 1) ? 1 : (m > 12) ? 12 : int'(m);
        dd = longint'(d) + off;
        yr = longint'(y);
        // whole 400-year cycles
        while (dd > dad_pkg::CYCLE_DAYS + 31)
        begin
            dd -= dad_pkg::CYCLE_DAYS;
            yr += dad_pkg::CYCLE_YEARS;
        end
        while (dd < 1 - dad_pkg::CYCLE_DAYS)
        begin
            dd += dad_pkg::CYCLE_DAYS;
            yr -= dad_pkg::CYCLE_YEARS;
        end
        // forward walk
        while (dd > days_in_month(mo, yr))
        begin
            dd -= days_in_month(mo, yr);
            mo++;
            if (mo > 12)
            begin
                mo = 1;
                yr++;
            end
        end
        // backward walk
        while (dd < 1)
        begin
            mo--;
            if (mo < 1)
            begin
                mo = 12;
                yr--;
            end
            dd += days_in_month(mo, yr);
        end
        if (yr < 0)
            res = '{day: 5'd1, month: 4'd1, year: 14'd0, range_error: 1'b1};
        else if (yr > dad_pkg::YEAR_MAX)
            res = '{day: 5'd31, month: 4'd12, year: 14'(dad_pkg::YEAR_MAX), range_error: 1'b1};
        else
            res = '{day: dd[4:0], month: 4'(mo), year: yr[13:0], range_error: 1'b0};
        return res;
    endfunction

    task automatic flag_failure(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $realtime, what);
    endtask

    always @(posedge clk)
    begin
        shifted_date_t want;
        if (rst_n)
        begin
            // results first: a result never belongs to an item accepted at the same edge
            if (out_valid && !out_stall)
            begin
                if (expected_dates.size() == 0)
                    flag_failure($sformatf("unexpected result %0d/%0d/%0d err %0b",
                                           new_day, new_month, new_year, range_error));
                else
                begin
                    want = expected_dates.pop_front();
                    if (new_day !== want.day || new_month !== want.month
                            || new_year !== want.year || range_error !== want.range_error)
                        flag_failure($sformatf(
                            "date mismatch: expected %0d/%0d/%0d err %0b, got %0d/%0d/%0d err %0b",
                            want.day, want.month, want.year, want.range_error,
                            new_day, new_month, new_year, range_error));
                end
            end
            if (in_valid && !in_stall)
                expected_dates.push_back(shift_date(day, month, year, longint'(offset)));
            pending <= expected_dates.size();
        end
    end

endmodule

// ===== dv/date_add_days_tb.sv =====
// testbench top for the date offset block: clock, reset, stimulus and verdict
// depends on date_add_days, dad_pkg and date_add_days_checker
`timescale 1ns / 1ps

module date_add_days_tb;

    localparam int OFFSET_BITS   = 16;
    localparam int CLK_PERIOD    = 10;
    localparam int ITEMS_PHASE   = 180;
    localparam int HOLD_CYCLES   = 3000;
    // covers the longest item, so any late result shows up
    localparam int DRAIN_CYCLES  = 1200;
    localparam int TIMEOUT_NS    = 35_000_000;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [4:0]                    day;
    logic [3:0]                    month;
    logic [13:0]                   year;
    logic signed [OFFSET_BITS-1:0] offset;
    logic                          out_valid;
    logic                          out_stall;
    logic [4:0]                    new_day;
    logic [3:0]                    new_month;
    logic [13:0]                   new_year;
    logic                          range_error;

    int mismatches;
    int pending;

    // idle rates in percent, set per phase by the stimulus
    int tx_idle_pct;
    int rx_idle_pct;
    // long receiver hold-offs asked for and carried out
    int holds_asked;
    int holds_done;

    date_add_days #(
        .OFFSET_BITS (OFFSET_BITS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .day         (day),
        .month       (month),
        .year        (year),
        .offset      (offset),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .new_day     (new_day),
        .new_month   (new_month),
        .new_year    (new_year),
        .range_error (range_error)
    );

    date_add_days_checker #(
        .OFFSET_BITS (OFFSET_BITS)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .day         (day),
        .month       (month),
        .year        (year),
        .offset      (offset),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .new_day     (new_day),
        .new_month   (new_month),
        .new_year    (new_year),
        .range_error (range_error),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    initial
        clk = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    // hard stop in case the block hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("date_add_days_tb failed");
        $finish;
    end

    // receiver: random stall, or a long hold-off when one is asked for so that
    // the output register and the sequencer both fill and the block stalls its input
    initial
    begin
        out_stall  = 1'b0;
        holds_done = 0;
        forever
        begin
            @(posedge clk);
            if (holds_done != holds_asked)
            begin
                holds_done++;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // offers one item, with random idle cycles first, and returns at the edge
    // where it is taken; valid stays high when the next item follows at once
    task automatic offer_date(input int d, input int m, input int y, input int off);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        day      <= d[4:0];
        month    <= m[3:0];
        year     <= y[13:0];
        offset   <= off[OFFSET_BITS-1:0];
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // sender pauses until every outstanding result has come back
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // offsets mostly short so that the month walk stays quick; a few span the full range
    function automatic int pick_offset();
        int pick;
        int mag;
        pick = $urandom_range(99);
        if (pick < 55)
            mag = $urandom_range(400);
        else if (pick < 85)
            mag = $urandom_range(4000);
        else
            mag = $urandom_range(32767);
        return $urandom_range(1) ? -mag : mag;
    endfunction

    // mostly valid start dates with years biased to both ends of the range;
    // the rest are raw bit patterns: day 0, months 0 and 13..15, years past 9999
    task automatic offer_random_date();
        int d;
        int m;
        int y;
        int max_day;
        if ($urandom_range(99) < 15)
            offer_date($urandom_range(31), $urandom_range(15), $urandom_range(16383),
                       $urandom_range(65535) - 32768);
        else
        begin
            m = $urandom_range(12, 1);
            case ($urandom_range(9))
                0: y = $urandom_range(60);
                1: y = $urandom_range(9999, 9940);
                2: y = 100 * $urandom_range(99);
                default: y = $urandom_range(9999);
            endcase
            if (m == 2)
                max_day = (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0)) ? 29 : 28;
            else if (m == 4 || m == 6 || m == 9 || m == 11)
                max_day = 30;
            else
                max_day = 31;
            // lean on the month ends, where the carries happen
            d = $urandom_range(3) == 0 ? max_day - $urandom_range(1) : $urandom_range(max_day, 1);
            offer_date(d, m, y, pick_offset());
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        day         = '0;
        month       = '0;
        year        = '0;
        offset      = '0;
        tx_idle_pct = 21;
        rx_idle_pct = 66;
        holds_asked = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: year and month wrap in both directions
        offer_date(1, 1, 2000, 0);
        offer_date(31, 12, 1999, 1);
        offer_date(1, 1, 2000, -1);
        // leap rule: every 400 years, not every 100, every 4
        offer_date(28, 2, 2000, 1);
        offer_date(28, 2, 1900, 1);
        offer_date(28, 2, 2024, 1);
        offer_date(1, 3, 2023, -1);
        offer_date(29, 2, 2000, 365);
        // results falling off either end of the year range
        offer_date(1, 1, 0, -1);
        offer_date(31, 12, 9999, 1);
        offer_date(1, 1, 0, -32768);
        offer_date(31, 12, 9999, 32767);
        offer_date(1, 1, 5000, 32767);
        offer_date(1, 1, 5000, -32768);
        // day of 0 and one past the month's end roll into the neighbouring month
        offer_date(0, 5, 2010, 0);
        offer_date(31, 4, 2010, 0);
        // month of 0 counts as January, above 12 as December
        offer_date(15, 0, 2001, 0);
        offer_date(15, 15, 2001, 0);
        // year above 9999 on input
        offer_date(1, 1, 16383, 0);
        offer_date(31, 15, 16383, -32768);
        offer_date(1, 1, 10000, -32768);
        offer_date(0, 0, 0, 0);
        wait_results_drained();

        // random: three idle patterns, each ended by a full drain
        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 66 : 0;
            rx_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 21 : 0;
            for (int i = 0; i < ITEMS_PHASE; i++)
            begin
                if (phase == 2 && i == ITEMS_PHASE / 3)
                begin
                    // receiver holds off while short items keep coming
                    holds_asked++;
                    for (int k = 0; k < 6; k++)
                        offer_date($urandom_range(28, 1), $urandom_range(12, 1),
                                   $urandom_range(9999), $urandom_range(40));
                end
                offer_random_date();
            end
            wait_results_drained();
        end

        // let any stray late result show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("date_add_days_tb passed");
        else
            $display("date_add_days_tb failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/dad_pkg.sv
rtl/dad_month_unit.sv
rtl/date_add_days.sv
dv/date_add_days_checker.sv
dv/date_add_days_tb.sv
